>>> rtl/gtm_pkg.sv
// Shared types, widths and codes for the gesture to mouse event block.
// No dependencies.
package gtm_pkg;

    localparam int DEF_COORD_WIDTH = 12;
    localparam int DEF_COUNT_WIDTH = 8;

    localparam int SCR_W      = 14;
    localparam int FRAME_W    = 8;
    localparam int FING_W     = 4;
    localparam int EV_W       = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EV_W-1:0] EV_CLICK  = 3'd1;
    localparam logic [EV_W-1:0] EV_DOUBLE = 3'd2;
    localparam logic [EV_W-1:0] EV_DOWN   = 3'd3;
    localparam logic [EV_W-1:0] EV_UP     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_RIGHT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_BOTTOM = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATE   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT = 4'd7;

    localparam int ROI_RIGHT_RST  = 639;
    localparam int ROI_BOTTOM_RST = 479;
    localparam logic [FRAME_W-1:0] ACTIVATE_RST = 8'd5;
    localparam logic [FRAME_W-1:0] RELEASE_RST  = 8'd5;
    localparam logic [SCR_W-1:0]   SCR_WIDTH_RST  = 14'd1920;
    localparam logic [SCR_W-1:0]   SCR_HEIGHT_RST = 14'd1080;

    typedef struct packed {
        logic              step;
        logic              in_region;
        logic [FING_W-1:0] fingers;
    } t_gest_ctl;

endpackage

>>> rtl/gtm_div.sv
// Shared scaling unit: one multiply, then restoring division one bit per cycle.
// Depends on gtm_pkg.
module gtm_div import gtm_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COORD_WIDTH-1:0] i_p,
    input  logic [COORD_WIDTH-1:0] i_lo,
    input  logic [COORD_WIDTH-1:0] i_hi,
    input  logic [SCR_W-1:0]       i_size,
    output logic                   o_done,
    output logic [SCR_W-1:0]       o_quot
);

    localparam int NUM_W = COORD_WIDTH + SCR_W;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_DIV  = 4'b0100,
        D_DONE = 4'b1000
    } t_dstate;

    t_dstate                r_state, n_state;
    logic [COORD_WIDTH-1:0] r_diff, r_span, r_rem, n_rem;
    logic [SCR_W-1:0]       r_size;
    logic [NUM_W-1:0]       r_num, r_q;
    logic [CNT_W-1:0]       r_cnt;
    logic [COORD_WIDTH:0]   trial, trial_sub;
    logic                   ge;

    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign ge        = trial >= {1'b0, r_span};
    assign trial_sub = trial - {1'b0, r_span};
    assign n_rem     = ge ? trial_sub[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_start) n_state = D_MUL;
            D_MUL:   n_state = D_DIV;
            D_DIV:   if (r_cnt == '0) n_state = D_DONE;
            D_DONE:  n_state = i_start ? D_MUL : D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == D_IDLE || r_state == D_DONE)) begin
            r_diff <= i_p - i_lo;
            r_span <= i_hi - i_lo;
            r_size <= i_size;
        end
        if (r_state == D_MUL) begin
            r_num <= NUM_W'(r_diff) * NUM_W'(r_size);
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_W - 1);
        end
        if (r_state == D_DIV) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = (r_state == D_DONE);
    assign o_quot = (r_span == '0) ? '0 : r_q[SCR_W-1:0];

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == D_IDLE || r_state == D_DONE))
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("divider done held");

endmodule

>>> rtl/gtm_gesture.sv
// Gesture flags, arm/release counters and event decision, one update per frame.
// Depends on gtm_pkg.
module gtm_gesture import gtm_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_gest_ctl          i_ctl,
    input  logic [FRAME_W-1:0] i_activate,
    input  logic [FRAME_W-1:0] i_rel,
    output logic [EV_W-1:0]    o_event
);

    localparam int CMP_W = (COUNT_WIDTH > FRAME_W) ? COUNT_WIDTH : FRAME_W;

    logic                   r_held, r_click, r_double;
    logic                   n_held, n_click, n_double;
    logic [COUNT_WIDTH-1:0] r_c_arm, r_c_rel, r_d_arm, r_d_rel, r_h_arm, r_h_rel, r_out;
    logic [COUNT_WIDTH-1:0] n_c_arm, n_c_rel, n_d_arm, n_d_rel, n_h_arm, n_h_rel, n_out;
    logic [CMP_W-1:0]       act_x, rel_x;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [CMP_W-1:0] ext(input logic [COUNT_WIDTH-1:0] c);
        return CMP_W'(c);
    endfunction

    assign act_x = CMP_W'(i_activate);
    assign rel_x = CMP_W'(i_rel);

    always_comb begin
        logic       big, four, two;
        n_held = r_held; n_click = r_click; n_double = r_double;
        n_c_arm = r_c_arm; n_c_rel = r_c_rel;
        n_d_arm = r_d_arm; n_d_rel = r_d_rel;
        n_h_arm = r_h_arm; n_h_rel = r_h_rel;
        n_out = r_out;
        o_event = EV_NONE;
        big  = i_ctl.fingers >= 4'd5;
        four = i_ctl.fingers == 4'd4;
        two  = i_ctl.fingers == 4'd2 || i_ctl.fingers == 4'd3;
        if (i_ctl.step) begin
            if (i_ctl.in_region) begin
                n_out = '0;
                if (big && !r_held && r_h_arm == '0 && !r_double && r_d_arm == '0) begin
                    n_c_rel = '0;
                    if (!r_click) begin
                        n_c_arm = bump(r_c_arm);
                        if (ext(n_c_arm) >= act_x) begin
                            n_c_arm = '0; n_click = 1'b1; o_event = EV_CLICK;
                        end
                    end
                end else if (four && !r_held && r_h_arm == '0 && !r_click
                             && r_c_arm == '0) begin
                    n_d_rel = '0;
                    if (!r_double) begin
                        n_d_arm = bump(r_d_arm);
                        if (ext(n_d_arm) >= act_x) begin
                            n_d_arm = '0; n_double = 1'b1; o_event = EV_DOUBLE;
                        end
                    end
                end else if (two && !r_double && r_d_arm == '0 && !r_click
                             && r_c_arm == '0) begin
                    n_h_rel = '0;
                    if (!r_held) begin
                        n_h_arm = bump(r_h_arm);
                        if (ext(n_h_arm) >= act_x) begin
                            n_h_arm = '0; n_held = 1'b1; o_event = EV_DOWN;
                        end
                    end
                end else if (r_click) begin
                    if (ext(r_c_rel) >= rel_x) n_click = 1'b0;
                    else n_c_rel = bump(r_c_rel);
                end else if (r_double) begin
                    if (ext(r_d_rel) >= rel_x) n_double = 1'b0;
                    else n_d_rel = bump(r_d_rel);
                end else if (r_held) begin
                    if (ext(r_h_rel) >= rel_x) begin
                        n_held = 1'b0; o_event = EV_UP;
                    end else begin
                        n_h_rel = bump(r_h_rel);
                    end
                end else if (r_c_arm != '0) begin
                    if (ext(r_c_rel) >= rel_x) n_c_arm = '0;
                    else n_c_rel = bump(r_c_rel);
                end else if (r_d_arm != '0) begin
                    if (ext(r_d_rel) >= rel_x) n_d_arm = '0;
                    else n_d_rel = bump(r_d_rel);
                end else if (r_h_arm != '0) begin
                    if (ext(r_h_rel) >= rel_x) n_h_arm = '0;
                    else n_h_rel = bump(r_h_rel);
                end
            end else if (ext(r_out) >= rel_x) begin
                if (r_held) o_event = EV_UP;
                n_held = 1'b0; n_click = 1'b0; n_double = 1'b0;
                n_c_arm = '0; n_c_rel = '0;
                n_d_arm = '0; n_d_rel = '0;
                n_h_arm = '0; n_h_rel = '0;
            end else begin
                n_out = bump(r_out);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0; r_click <= 1'b0; r_double <= 1'b0;
            r_c_arm <= '0; r_c_rel <= '0;
            r_d_arm <= '0; r_d_rel <= '0;
            r_h_arm <= '0; r_h_rel <= '0;
            r_out <= '0;
        end else begin
            r_held <= n_held; r_click <= n_click; r_double <= n_double;
            r_c_arm <= n_c_arm; r_c_rel <= n_c_rel;
            r_d_arm <= n_d_arm; r_d_rel <= n_d_rel;
            r_h_arm <= n_h_arm; r_h_rel <= n_h_rel;
            r_out <= n_out;
        end
    end

    a_one_gesture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_held, r_click, r_double}))
        else $error("more than one gesture active");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.step |=> $stable({r_held, r_click, r_double, r_out}))
        else $error("gesture state changed without a frame");

endmodule

>>> rtl/gesture_to_mouse_event_fsm.sv
// Top level: channels, configuration registers, frame sequencer, result register.
// Depends on gtm_pkg, gtm_div, gtm_gesture.
//
// Input channel (i_in_valid / o_in_stall) takes one camera frame: pointer flag,
// pointer position and fingertip count. Output channel (o_out_valid / i_out_stall)
// gives exactly one result per frame: move flag, screen position, event code.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the region,
// the activate/release frame counts and the screen size; write only while idle.
// Gesture state is updated at the input transfer. A frame inside the
// region is scaled by one shared multiply-and-divide unit, first x then y; each
// pass is a multiply step followed by restoring division, one bit of quotient per
// cycle. Any other frame goes straight to the result step. One frame is in work
// at a time; o_in_stall is high from the transfer until the result is placed in
// the output register. The output register holds a result while the receiver
// stalls, and the next frame may be taken and worked on meanwhile; it then waits
// for the register. Synchronous reset clears all gesture flags and counters and
// the output valid flag, and restores the configuration defaults (region
// 0,0..639,479, 5/5, 1920x1080).
module gesture_to_mouse_event_fsm import gtm_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_pointer_valid,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    input  logic [FING_W-1:0]      i_finger_count,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_move_valid,
    output logic [SCR_W-1:0]       o_screen_x,
    output logic [SCR_W-1:0]       o_screen_y,
    output logic [EV_W-1:0]        o_event_code,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_X    = 4'b0010,
        S_Y    = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [COORD_WIDTH-1:0] r_left, r_top, r_right, r_bottom, r_py;
    logic [FRAME_W-1:0]     r_act, r_rel;
    logic [SCR_W-1:0]       r_width, r_height, r_sx, r_sy;
    logic                   r_move;
    logic [EV_W-1:0]        r_ev;
    logic                   r_out_valid, n_out_valid;

    logic                   in_xfer, in_region, out_load;
    logic                   div_start, div_done;
    logic [COORD_WIDTH-1:0] div_p, div_lo, div_hi;
    logic [SCR_W-1:0]       div_size, div_q;
    logic [EV_W-1:0]        gest_ev;
    t_gest_ctl              gest_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign in_region   = i_point_x >= r_left && i_point_x <= r_right
                      && i_point_y >= r_top && i_point_y <= r_bottom;
    assign out_load    = (r_state == S_WB) && (!r_out_valid || !i_out_stall);

    assign gest_ctl.step      = in_xfer && i_pointer_valid;
    assign gest_ctl.in_region = in_region;
    assign gest_ctl.fingers   = i_finger_count;

    assign div_start = (gest_ctl.step && in_region) || (r_state == S_X && div_done);
    assign div_p     = (r_state == S_X) ? r_py     : i_point_x;
    assign div_lo    = (r_state == S_X) ? r_top    : r_left;
    assign div_hi    = (r_state == S_X) ? r_bottom : r_right;
    assign div_size  = (r_state == S_X) ? r_height : r_width;

    gtm_div #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_p    (div_p),
        .i_lo   (div_lo),
        .i_hi   (div_hi),
        .i_size (div_size),
        .o_done (div_done),
        .o_quot (div_q)
    );

    gtm_gesture #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_gesture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (gest_ctl),
        .i_activate(r_act),
        .i_rel     (r_rel),
        .o_event   (gest_ev)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_xfer) n_state = (i_pointer_valid && in_region) ? S_X : S_WB;
            S_X:     if (div_done) n_state = S_Y;
            S_Y:     if (div_done) n_state = S_WB;
            S_WB:    if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_top       <= '0;
            r_right     <= COORD_WIDTH'(ROI_RIGHT_RST);
            r_bottom    <= COORD_WIDTH'(ROI_BOTTOM_RST);
            r_act       <= ACTIVATE_RST;
            r_rel       <= RELEASE_RST;
            r_width     <= SCR_WIDTH_RST;
            r_height    <= SCR_HEIGHT_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ROI_LEFT:   r_left   <= i_cfg_data[COORD_WIDTH-1:0];
                    CFG_ROI_TOP:    r_top    <= i_cfg_data[COORD_WIDTH-1:0];
                    CFG_ROI_RIGHT:  r_right  <= i_cfg_data[COORD_WIDTH-1:0];
                    CFG_ROI_BOTTOM: r_bottom <= i_cfg_data[COORD_WIDTH-1:0];
                    CFG_ACTIVATE:   r_act    <= i_cfg_data[FRAME_W-1:0];
                    CFG_RELEASE:    r_rel    <= i_cfg_data[FRAME_W-1:0];
                    CFG_SCR_WIDTH:  r_width  <= i_cfg_data[SCR_W-1:0];
                    CFG_SCR_HEIGHT: r_height <= i_cfg_data[SCR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_move <= i_pointer_valid && in_region;
            r_ev   <= gest_ctl.step ? gest_ev : EV_NONE;
            r_py   <= i_point_y;
            r_sx   <= '0;
            r_sy   <= '0;
        end
        if (r_state == S_X && div_done) r_sx <= div_q;
        if (r_state == S_Y && div_done) r_sy <= div_q;
        if (out_load) begin
            o_move_valid <= r_move;
            o_screen_x   <= r_sx;
            o_screen_y   <= r_sy;
            o_event_code <= r_ev;
        end
    end

    assign o_out_valid = r_out_valid;

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("frame taken while a frame is in work");

    a_no_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_move_valid) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("screen position without a move");

    a_done_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_X || r_state == S_Y))
        else $error("scaling result outside a scaling step");

endmodule
